[hdl/uart_rx_idle_timeout_framer_core_assert.svh]
// assertion macros shared by the framer modules
`ifndef UART_RX_IDLE_TIMEOUT_FRAMER_CORE_ASSERT_SVH
`define UART_RX_IDLE_TIMEOUT_FRAMER_CORE_ASSERT_SVH

// same-cycle implication
`define UITF_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("framer assertion failed");

// next-cycle implication
`define UITF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("framer assertion failed");

`endif

[hdl/uitf_pkg.sv]
package uitf_pkg;

   localparam int COUNT_W = 17;
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic [15:0] TIMEOUT_RESET = 16'd10;
   localparam int CSR_AW = 3;
   localparam logic CSR_IDLE_TIMEOUT = 1'b0;

   typedef enum logic [1:0] {
      REQ_BYTE = 2'd0,
      REQ_TICK = 2'd1,
      REQ_READ = 2'd2,
      REQ_ACK  = 2'd3
   } req_kind_type;

   typedef struct packed {
      logic       pending;
      logic [7:0] length;
      logic       receiving;
      logic       done;
   } status_type;

endpackage

[hdl/uart_rx_idle_timeout_framer_core.sv]
// Idle-timeout packet framer for one serial receive channel.
// req channel: one beat per event; req_tuser carries the kind (received byte,
// timer tick, read of a stored byte, acknowledge of a pending packet),
// req_tdata carries the byte and the read position.
// rsp channel: exactly one beat per req beat, in order, carrying the status
// after that event plus the read byte (zero unless a read of an index below BUF_DEPTH).
// From req acceptance to rsp valid a result passes the ram read stage (the byte
// store is a synchronous ram with a registered read port) and then one output
// register. One beat is accepted per cycle when rsp_tready stays high.
// When rsp stalls, one result waits in the output register and one more in
// the ram read stage; req_tready drops only while both are occupied.
// Reset clears the write position, silence count, flags and packet length,
// and sets idle_timeout to 10. The byte store is not cleared; reading a
// position that was never written returns an undefined byte.
// the user writes idle_timeout via csr port address 0 only while idle; unchecked.
module uart_rx_idle_timeout_framer_core #(
   parameter int BUF_DEPTH = 256
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [15:0]                req_tdata,  // rx_byte[7:0], read_index[15:8]
   input  logic [1:0]                 req_tuser,  // req_type[1:0]
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // read_data[7:0], packet_pending[8], packet_length[16:9], receiving[17],
   // packet_done[18], zero[23:19]
   output logic [23:0]                rsp_tdata,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [uitf_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);
   import uitf_pkg::*;
   `include "uart_rx_idle_timeout_framer_core_assert.svh"

   localparam int AW = $clog2(BUF_DEPTH);

   logic [15:0]   timeout_ff;
   logic          csr_write;
   logic          req_accept;
   req_kind_type  kind;
   logic [7:0]    rx_byte;
   logic [7:0]    read_index;
   logic          index_ok;
   logic [AW-1:0] write_pos;
   status_type    status;
   logic [7:0]    ram_rd_data;

   logic          s1_valid_ff, s1_valid_in;
   status_type    s1_status_ff;
   logic          s1_read_ff;
   logic          s1_move;
   logic          out_valid_ff, out_valid_in;
   status_type    out_status_ff;
   logic [7:0]    out_data_ff;

   // configuration
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == CSR_IDLE_TIMEOUT) ? {16'd0, timeout_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_write && csr_paddr[2] == CSR_IDLE_TIMEOUT) begin
         timeout_ff <= csr_pwdata[15:0];
      end
   end

   // request decode
   assign kind       = req_kind_type'(req_tuser);
   assign rx_byte    = req_tdata[7:0];
   assign read_index = req_tdata[15:8];
   assign index_ok   = 32'(read_index) < BUF_DEPTH;

   assign s1_move    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_move;
   assign req_accept = req_tvalid && req_tready;

   uitf_ctrl #(
      .BUF_DEPTH(BUF_DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .kind        (kind),
      .idle_timeout(timeout_ff),
      .write_pos   (write_pos),
      .status      (status)
   );

   uitf_ram #(
      .WIDTH(8),
      .DEPTH(BUF_DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (req_accept && kind == REQ_BYTE),
      .wr_addr(write_pos),
      .wr_data(rx_byte),
      .rd_en  (req_accept && kind == REQ_READ),
      .rd_addr(AW'(read_index)),
      .rd_data(ram_rd_data)
   );

   // ram read stage, then output register
   assign s1_valid_in  = req_accept || (s1_valid_ff && !s1_move);
   assign out_valid_in = s1_move || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_status_ff <= status;
         s1_read_ff   <= (kind == REQ_READ) && index_ok;
      end
      if (s1_move) begin
         out_status_ff <= s1_status_ff;
         out_data_ff   <= s1_read_ff ? ram_rd_data : 8'd0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_status_ff.done, out_status_ff.receiving,
                        out_status_ff.length, out_status_ff.pending, out_data_ff};

   `UITF_ASSERT_NOW(a_no_accept_when_full, clock, reset,
      s1_valid_ff && !s1_move, !req_accept)
   `UITF_ASSERT_NOW(a_done_flags, clock, reset, out_valid_ff && out_status_ff.done,
      out_status_ff.pending && !out_status_ff.receiving)
   `UITF_ASSERT_NEXT(a_stage_moves, clock, reset, s1_move, out_valid_ff)

endmodule

[hdl/uitf_ram.sv]
module uitf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/uitf_ctrl.sv]
module uitf_ctrl #(
   parameter int BUF_DEPTH = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  uitf_pkg::req_kind_type       kind,
   input  logic [15:0]                  idle_timeout,
   output logic [$clog2(BUF_DEPTH)-1:0] write_pos,
   output uitf_pkg::status_type         status
);
   import uitf_pkg::*;
   `include "uart_rx_idle_timeout_framer_core_assert.svh"

   localparam int AW = $clog2(BUF_DEPTH);
   localparam logic [AW-1:0] LAST_POS = AW'(BUF_DEPTH - 1);

   logic [AW-1:0]      write_pos_ff, write_pos_in;
   logic [COUNT_W-1:0] count_ff, count_in, count_inc;
   logic               busy_ff, busy_in;
   logic               waiting_ff, waiting_in;
   logic [AW-1:0]      length_ff, length_in;
   logic               done;

   assign count_inc = (count_ff < COUNT_MAX) ? count_ff + 1'b1 : count_ff;

   always_comb begin
      write_pos_in = write_pos_ff;
      count_in     = count_ff;
      busy_in      = busy_ff;
      waiting_in   = waiting_ff;
      length_in    = length_ff;
      done         = 1'b0;
      case (kind)
         REQ_BYTE: begin
            write_pos_in = (write_pos_ff == LAST_POS) ? '0 : write_pos_ff + 1'b1;
            count_in     = COUNT_W'(1);
            busy_in      = 1'b1;
         end
         REQ_TICK: begin
            if (busy_ff) begin
               count_in = count_inc;
               // packet ends once silence exceeds the timeout
               if (count_inc > {1'b0, idle_timeout}) begin
                  busy_in      = 1'b0;
                  waiting_in   = 1'b1;
                  length_in    = write_pos_ff;
                  write_pos_in = '0;
                  done         = 1'b1;
               end
            end
         end
         REQ_ACK: waiting_in = 1'b0;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_pos_ff <= '0;
         count_ff     <= '0;
         busy_ff      <= 1'b0;
         waiting_ff   <= 1'b0;
         length_ff    <= '0;
      end else if (accept) begin
         write_pos_ff <= write_pos_in;
         count_ff     <= count_in;
         busy_ff      <= busy_in;
         waiting_ff   <= waiting_in;
         length_ff    <= length_in;
      end
   end

   assign write_pos        = write_pos_ff;
   assign status.pending   = waiting_in;
   assign status.length    = 8'(length_in);
   assign status.receiving = busy_in;
   assign status.done      = done;

   `UITF_ASSERT_NEXT(a_done_rewinds, clock, reset, accept && done,
      write_pos_ff == '0 && waiting_ff && !busy_ff)
   `UITF_ASSERT_NEXT(a_byte_sets_busy, clock, reset, accept && kind == REQ_BYTE,
      busy_ff && count_ff == COUNT_W'(1))
   `UITF_ASSERT_NOW(a_busy_count, clock, reset, busy_ff, count_ff != '0)

endmodule
